@@ sv/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and controller/datapath interface types of the command
// frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // Default depth of the payload buffer.
    localparam int DEF_PAYLOAD_DEPTH = 64;

    // Field widths.
    localparam int LEN_W  = 6;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int SUM_W  = 16;
    localparam int TICK_W = 16;

    // Frame framing bytes.
    localparam logic [7:0] START_CODE = 8'hCC;
    localparam logic [7:0] STOP_CODE  = 8'h99;

    // Request kind that carries a payload.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_SUM     = 2'd1;
    localparam logic [STAT_W-1:0] ST_STOP    = 2'd2;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd3;

    // Reset value of the timeout register.
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

    // Register index of timeout_ticks.
    localparam logic REG_TIMEOUT = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              clear_frame;
        logic              load_cmd;
        logic              store_pay;
        logic              load_hi;
        logic              load_lo;
        logic              tick;
        logic              out_err;
        logic              out_single;
        logic              emit_start;
        logic              emit_next;
        logic [STAT_W-1:0] err_code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic is_stop;
        logic has_payload;
        logic pay_done;
        logic sum_ok;
        logic len_zero;
        logic timeout_hit;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

@@ sv/cfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfr_ctrl
// Frame phase state machine: steers the datapath through a frame and through
// the release of buffered payload words.
// ----------------------------------------------------------------------------
module cfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_op,
    output logic          o_ready,
    input  cfr_pkg::t_stat i_stat,
    output cfr_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMD  = 3'd1;
    localparam logic [2:0] S_PAY  = 3'd2;
    localparam logic [2:0] S_SHI  = 3'd3;
    localparam logic [2:0] S_SLO  = 3'd4;
    localparam logic [2:0] S_STOP = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    // Every input word may produce one result, so words are taken only when
    // the output register is free or drains in this cycle.
    assign o_ready = (r_state != S_EMIT) && i_stat.out_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        if (r_state == S_EMIT) begin
            if (i_stat.out_free) begin
                o_cmd.emit_next = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
        end else if (accept && i_op) begin
            // Ticks only count inside a frame.
            if (r_state != S_IDLE) begin
                o_cmd.tick = 1'b1;
                if (i_stat.timeout_hit) begin
                    o_cmd.out_err  = 1'b1;
                    o_cmd.err_code = cfr_pkg::ST_TIMEOUT;
                    n_state        = S_IDLE;
                end
            end
        end else if (accept) begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_stat.is_start) begin
                        o_cmd.clear_frame = 1'b1;
                        n_state           = S_CMD;
                    end
                end
                S_CMD: begin
                    o_cmd.load_cmd = 1'b1;
                    n_state        = i_stat.has_payload ? S_PAY : S_SHI;
                end
                S_PAY: begin
                    o_cmd.store_pay = 1'b1;
                    if (i_stat.pay_done) begin
                        n_state = S_SHI;
                    end
                end
                S_SHI: begin
                    o_cmd.load_hi = 1'b1;
                    n_state       = S_SLO;
                end
                S_SLO: begin
                    o_cmd.load_lo = 1'b1;
                    n_state       = S_STOP;
                end
                S_STOP: begin
                    n_state = S_IDLE;
                    if (!i_stat.is_stop) begin
                        o_cmd.out_err  = 1'b1;
                        o_cmd.err_code = cfr_pkg::ST_STOP;
                    end else if (!i_stat.sum_ok) begin
                        o_cmd.out_err  = 1'b1;
                        o_cmd.err_code = cfr_pkg::ST_SUM;
                    end else if (i_stat.len_zero) begin
                        o_cmd.out_single = 1'b1;
                    end else begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_EMIT;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/cfr_dp.sv @@
// ----------------------------------------------------------------------------
// cfr_dp
// Frame datapath: command and length capture, running sum, checksum word,
// tick counter, timeout register, payload buffer and the output register.
// ----------------------------------------------------------------------------
module cfr_dp #(
    parameter int PAYLOAD_DEPTH = cfr_pkg::DEF_PAYLOAD_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [7:0]                   i_byte,
    input  logic                         i_cfg_we,
    input  logic [cfr_pkg::TICK_W-1:0]   i_cfg_data,
    output logic [cfr_pkg::TICK_W-1:0]   o_timeout,
    input  cfr_pkg::t_cmd                i_cmd,
    output cfr_pkg::t_stat               o_stat,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [cfr_pkg::KIND_W-1:0]   o_kind,
    output logic [cfr_pkg::STAT_W-1:0]   o_status,
    output logic [cfr_pkg::LEN_W-1:0]    o_len,
    output logic [cfr_pkg::LEN_W-1:0]    o_idx,
    output logic [7:0]                   o_data,
    output logic                         o_last
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    logic [7:0]                 r_mem [PAYLOAD_DEPTH];
    logic [7:0]                 r_rd_data;
    logic [AW-1:0]              rd_addr;

    logic [cfr_pkg::TICK_W-1:0] r_timeout;
    logic [cfr_pkg::TICK_W-1:0] r_tick;
    logic [cfr_pkg::TICK_W-1:0] n_tick;
    logic [7:0]                 r_cmd;
    logic [cfr_pkg::LEN_W-1:0]  r_len;
    logic [cfr_pkg::LEN_W-1:0]  r_cnt;
    logic [cfr_pkg::LEN_W-1:0]  n_cnt;
    logic [cfr_pkg::LEN_W-1:0]  r_idx;
    logic [cfr_pkg::SUM_W-1:0]  r_sum;
    logic [cfr_pkg::SUM_W-1:0]  r_chk;

    logic                       r_out_valid;
    logic [cfr_pkg::KIND_W-1:0] r_o_kind;
    logic [cfr_pkg::STAT_W-1:0] r_o_status;
    logic [cfr_pkg::LEN_W-1:0]  r_o_len;
    logic [cfr_pkg::LEN_W-1:0]  r_o_idx;
    logic [7:0]                 r_o_data;
    logic                       r_o_last;
    logic                       out_load;

    assign n_tick = (r_tick == '1) ? r_tick : r_tick + 1'b1;
    assign n_cnt  = r_cnt + 1'b1;

    always_comb begin
        o_stat.is_start    = (i_byte == cfr_pkg::START_CODE);
        o_stat.is_stop     = (i_byte == cfr_pkg::STOP_CODE);
        o_stat.has_payload = (i_byte[7:6] == cfr_pkg::KIND_WRITE)
                             && (i_byte[5:0] != '0);
        o_stat.pay_done    = (n_cnt >= r_len);
        o_stat.sum_ok      = (r_sum == r_chk);
        o_stat.len_zero    = (r_len == '0);
        o_stat.timeout_hit = (n_tick >= r_timeout);
        o_stat.emit_last   = (r_idx == r_len - 1'b1);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // The read address runs one word ahead of the output, so a buffered
    // payload word can leave on every cycle while the output register is free.
    always_comb begin
        if (i_cmd.emit_start) begin
            rd_addr = '0;
        end else if (i_cmd.emit_next) begin
            rd_addr = AW'(r_idx + 1'b1);
        end else begin
            rd_addr = AW'(r_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pay) begin
            r_mem[AW'(r_cnt)] <= i_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= cfr_pkg::TIMEOUT_RESET;
            r_tick    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cmd.clear_frame) begin
                r_tick <= '0;
            end else if (i_cmd.tick) begin
                r_tick <= n_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_frame) begin
            r_cmd <= '0;
            r_len <= '0;
            r_cnt <= '0;
            r_sum <= '0;
            r_chk <= '0;
        end
        if (i_cmd.load_cmd) begin
            r_cmd <= i_byte;
            r_sum <= {8'h00, i_byte};
            r_cnt <= '0;
            r_len <= (i_byte[7:6] == cfr_pkg::KIND_WRITE) ? i_byte[5:0] : '0;
        end
        if (i_cmd.store_pay) begin
            r_sum <= r_sum + {8'h00, i_byte};
            r_cnt <= n_cnt;
        end
        if (i_cmd.load_hi) begin
            r_chk <= {i_byte, 8'h00};
        end
        if (i_cmd.load_lo) begin
            r_chk <= {r_chk[15:8], i_byte};
        end
        if (i_cmd.emit_start) begin
            r_idx <= '0;
        end else if (i_cmd.emit_next) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    assign out_load = i_cmd.out_err || i_cmd.out_single || i_cmd.emit_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_err) begin
            r_o_kind   <= '0;
            r_o_status <= i_cmd.err_code;
            r_o_len    <= '0;
            r_o_idx    <= '0;
            r_o_data   <= '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.out_single) begin
            r_o_kind   <= r_cmd[7:6];
            r_o_status <= cfr_pkg::ST_OK;
            r_o_len    <= '0;
            r_o_idx    <= '0;
            r_o_data   <= '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.emit_next) begin
            r_o_kind   <= r_cmd[7:6];
            r_o_status <= cfr_pkg::ST_OK;
            r_o_len    <= r_len;
            r_o_idx    <= r_idx;
            r_o_data   <= r_rd_data;
            r_o_last   <= o_stat.emit_last;
        end
    end

    assign o_timeout   = r_timeout;
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_o_kind;
    assign o_status    = r_o_status;
    assign o_len       = r_o_len;
    assign o_idx       = r_o_idx;
    assign o_data      = r_o_data;
    assign o_last      = r_o_last;

endmodule

@@ sv/command_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver
// Serial command frame parser with an additive 16-bit checksum.
// ----------------------------------------------------------------------------
// The block takes one word per accepted input: a received serial byte in
// tdata when tuser is 0, or one timer tick when tuser is 1. A frame is the
// start byte 0xCC, a command byte whose top two bits give the request kind,
// for a write as many payload bytes as the low six command bits, a checksum
// sent high byte first that must equal the 16-bit sum of the command and
// payload bytes, and the stop byte 0x99. A good frame without payload yields
// one result word on its stop byte; a good write with payload releases its
// buffered bytes from the payload buffer, one result word per cycle while the
// output register is free, with tlast on the final one, and the input is held
// off while they leave. A bad stop byte, a checksum mismatch, or reaching the
// timeout_ticks register value in ticks counted since the start byte yields a
// single error result word. A single output register sits between the two
// sides, so an input word is taken only when that register is empty or drains
// in the same cycle and no buffered bytes are leaving. The only register,
// timeout_ticks, sits at byte address 0 of the APB port and should be written
// while the block is idle.
// ----------------------------------------------------------------------------
module command_frame_receiver #(
    parameter int PAYLOAD_DEPTH = cfr_pkg::DEF_PAYLOAD_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] operation
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] request_kind, [3:2] status, [9:4] payload_length,
    // [15:10] payload_index, [23:16] payload_byte
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast,   // last
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfr_pkg::t_cmd               cmd;
    cfr_pkg::t_stat              stat;
    logic                        cfg_we;
    logic [cfr_pkg::TICK_W-1:0]  timeout;
    logic [cfr_pkg::KIND_W-1:0]  out_kind;
    logic [cfr_pkg::STAT_W-1:0]  out_status;
    logic [cfr_pkg::LEN_W-1:0]   out_len;
    logic [cfr_pkg::LEN_W-1:0]   out_idx;
    logic [7:0]                  out_data;

    // The port never waits. Register index is paddr[2]; other indexes are
    // ignored on write and read back as zero.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == cfr_pkg::REG_TIMEOUT);

    always_comb begin
        if (paddr[2] == cfr_pkg::REG_TIMEOUT) begin
            prdata = {16'h0000, timeout};
        end else begin
            prdata = '0;
        end
    end

    cfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tuser),
        .o_ready (o_s_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cfr_dp #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_s_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (pwdata[15:0]),
        .o_timeout   (timeout),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_kind      (out_kind),
        .o_status    (out_status),
        .o_len       (out_len),
        .o_idx       (out_idx),
        .o_data      (out_data),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {out_data, out_idx, out_len, out_status, out_kind};

endmodule
